[src/fspd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspd_pkg: shared types and constants of the field swing power detector
// Widths of the register and result fields, register indexes, event codes
// and the request and response structs of the wattage mapping unit.
// ----------------------------------------------------------------------------
package fspd_pkg;

	// Default width of one field sample.
	localparam int FIELD_BITS_DEF = 24;

	// Fixed field widths.
	localparam int WINDOW_W = 16;
	localparam int SWING_W  = 24;
	localparam int WATTS_W  = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WATTS_MAX      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CALIBRATING    = 3'd4;

	// Register reset values.
	localparam logic [WINDOW_W-1:0] WINDOW_SAMPLES_RST = 16'd100;
	localparam logic [SWING_W-1:0]  AMPLITUDE_LOW_RST  = 24'd0;
	localparam logic [SWING_W-1:0]  AMPLITUDE_HIGH_RST = 24'd1000;
	localparam logic [WATTS_W-1:0]  WATTS_MAX_RST      = 16'd3000;

	// Saturation limits.
	localparam logic [SWING_W-1:0] SWING_MAX = '1;
	localparam logic [WATTS_W-1:0] WATTS_SAT = '1;

	// Power events.
	typedef enum logic [1:0] {
		EVT_NONE = 2'd0,
		EVT_ON   = 2'd1,
		EVT_OFF  = 2'd2
	} event_code_t;

	// Request to the wattage mapping unit.
	typedef struct packed {
		logic               start;
		logic [SWING_W-1:0] swing;
		logic [SWING_W-1:0] amp_low;
		logic [SWING_W-1:0] amp_high;
		logic [WATTS_W-1:0] watts_max;
	} map_req_t;

	// Response of the wattage mapping unit.
	typedef struct packed {
		logic               done;
		logic [WATTS_W-1:0] watts;
	} map_rsp_t;

endpackage

[src/fspd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspd_in_if: field sample channel
// Valid/ready channel that carries one signed field sample per transaction.
// ----------------------------------------------------------------------------
interface fspd_in_if
	import fspd_pkg::*;
#(
	parameter int FIELD_BITS = FIELD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [FIELD_BITS-1:0] field_z;

	modport source (output valid, output field_z, input ready);
	modport sink (input valid, input field_z, output ready);
endinterface

[src/fspd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspd_out_if: detector result channel
// Valid/ready channel that carries one detector result per transaction.
// ----------------------------------------------------------------------------
interface fspd_out_if
	import fspd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [WATTS_W-1:0] power_watts;
	logic [SWING_W-1:0] swing;
	logic               window_done;
	logic               power_on;
	logic [1:0]         event_code;

	modport source (
		output valid, output power_watts, output swing, output window_done,
		output power_on, output event_code, input ready
	);
	modport sink (
		input valid, input power_watts, input swing, input window_done,
		input power_on, input event_code, output ready
	);
endinterface

[src/fspd_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspd_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface fspd_cfg_if
	import fspd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

[src/field_swing_power_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_swing_power_detector_unit: peak-to-peak field swing power detector
// Tracks the window minimum and maximum of the field samples, maps each
// closed window's swing to watts and reports an on/off power state.
// ----------------------------------------------------------------------------
// One result comes out for every field sample. A sample that does not close
// a window moves through the finish state into the output register, and the
// block then takes the next sample. A sample that closes a window first waits
// for the wattage mapping unit, which runs a 16-step shift-add multiply and a
// 16-step restoring divide on one shared 25-bit adder. An empty range or a
// negative quotient maps to zero watts and skips both steps, and a saturated
// result skips the divide. The sample channel is not ready while a sample is
// in work, and a finished result waits in the output register until the sink
// takes it. Configuration writes are always accepted and are meant to happen
// only while the block is idle.
module field_swing_power_detector_unit
	import fspd_pkg::*;
#(
	parameter int FIELD_BITS = FIELD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fspd_in_if.sink    sample,
	fspd_out_if.source result,
	fspd_cfg_if.sink   cfg
);

	localparam logic signed [FIELD_BITS-1:0] FIELD_TOP    = {1'b0, {(FIELD_BITS-1){1'b1}}};
	localparam logic signed [FIELD_BITS-1:0] FIELD_BOTTOM = {1'b1, {(FIELD_BITS-1){1'b0}}};
	localparam int DW = (FIELD_BITS + 1 > SWING_W) ? FIELD_BITS + 1 : SWING_W;

	typedef enum logic [1:0] {
		T_IDLE,
		T_MAP,
		T_FIN
	} top_state_t;

	top_state_t                   state_q;
	logic [WINDOW_W-1:0]          window_samples_q;
	logic [SWING_W-1:0]           amplitude_low_q;
	logic [SWING_W-1:0]           amplitude_high_q;
	logic [WATTS_W-1:0]           watts_max_q;
	logic                         calibrating_q;
	logic signed [FIELD_BITS-1:0] window_min_q;
	logic signed [FIELD_BITS-1:0] window_max_q;
	logic [WINDOW_W-1:0]          sample_count_q;
	logic [SWING_W-1:0]           last_swing_q;
	logic [WATTS_W-1:0]           last_watts_q;
	logic                         power_state_q;
	logic                         done_q;
	logic                         res_valid_q;
	logic [WATTS_W-1:0]           res_watts_q;
	logic [SWING_W-1:0]           res_swing_q;
	logic                         res_done_q;
	logic                         res_pow_q;
	event_code_t                  res_evt_q;

	logic                         sample_acc;
	logic                         res_load;
	logic signed [FIELD_BITS-1:0] x;
	logic signed [FIELD_BITS-1:0] min_n;
	logic signed [FIELD_BITS-1:0] max_n;
	logic [FIELD_BITS:0]          diff;
	logic [DW-1:0]                diff_ext;
	logic [SWING_W-1:0]           swing_next;
	logic [WINDOW_W-1:0]          cnt_next;
	logic [WINDOW_W-1:0]          limit;
	logic                         close;
	logic                         watts_on;
	logic                         pow_next;
	event_code_t                  evt_next;
	map_req_t                     map_req;
	map_rsp_t                     map_rsp;

	assign sample.ready = (state_q == T_IDLE);
	assign sample_acc   = sample.valid && sample.ready;
	assign cfg.ready    = 1'b1;

	// The output register takes a new result once it is empty or being drained.
	assign res_load = (state_q == T_FIN) && (!res_valid_q || result.ready);

	// Window extremes and the swing they span once this sample is included.
	assign x     = sample.field_z;
	assign min_n = (x < window_min_q) ? x : window_min_q;
	assign max_n = (x > window_max_q) ? x : window_max_q;
	assign diff  = {max_n[FIELD_BITS-1], max_n} - {min_n[FIELD_BITS-1], min_n};
	assign diff_ext = DW'(diff);

	always_comb begin
		if (diff_ext > DW'(SWING_MAX)) begin
			swing_next = SWING_MAX;
		end else begin
			swing_next = diff_ext[SWING_W-1:0];
		end
	end

	// Window close test; a zero window length acts as one sample.
	assign cnt_next = sample_count_q + 1'b1;
	assign limit    = (window_samples_q == '0) ? WINDOW_W'(1) : window_samples_q;
	assign close    = (cnt_next >= limit);

	// Power state follows the latest wattage unless calibration freezes it.
	assign watts_on = (last_watts_q != '0);
	always_comb begin
		pow_next = power_state_q;
		evt_next = EVT_NONE;
		if (!calibrating_q) begin
			if (watts_on && !power_state_q) begin
				pow_next = 1'b1;
				evt_next = EVT_ON;
			end else if (!watts_on && power_state_q) begin
				pow_next = 1'b0;
				evt_next = EVT_OFF;
			end
		end
	end

	// Wattage mapping unit, started by a window-closing sample.
	assign map_req.start     = sample_acc && close;
	assign map_req.swing     = swing_next;
	assign map_req.amp_low   = amplitude_low_q;
	assign map_req.amp_high  = amplitude_high_q;
	assign map_req.watts_max = watts_max_q;

	fspd_map_unit u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.rsp    (map_rsp)
	);

	// Control sequence, window state, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= T_IDLE;
			window_samples_q <= WINDOW_SAMPLES_RST;
			amplitude_low_q  <= AMPLITUDE_LOW_RST;
			amplitude_high_q <= AMPLITUDE_HIGH_RST;
			watts_max_q      <= WATTS_MAX_RST;
			calibrating_q    <= 1'b0;
			window_min_q     <= FIELD_TOP;
			window_max_q     <= FIELD_BOTTOM;
			sample_count_q   <= '0;
			last_swing_q     <= '0;
			last_watts_q     <= '0;
			power_state_q    <= 1'b0;
			done_q           <= 1'b0;
			res_valid_q      <= 1'b0;
			res_watts_q      <= '0;
			res_swing_q      <= '0;
			res_done_q       <= 1'b0;
			res_pow_q        <= 1'b0;
			res_evt_q        <= EVT_NONE;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_WINDOW_SAMPLES: window_samples_q <= cfg.wdata[WINDOW_W-1:0];
					REG_AMPLITUDE_LOW:  amplitude_low_q  <= cfg.wdata[SWING_W-1:0];
					REG_AMPLITUDE_HIGH: amplitude_high_q <= cfg.wdata[SWING_W-1:0];
					REG_WATTS_MAX:      watts_max_q      <= cfg.wdata[WATTS_W-1:0];
					REG_CALIBRATING:    calibrating_q    <= cfg.wdata[0];
					default: begin
						calibrating_q <= calibrating_q;
					end
				endcase
			end

			// Output valid: set by a new result, cleared when the sink takes it.
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				T_IDLE: begin
					if (sample_acc) begin
						if (close) begin
							window_min_q   <= FIELD_TOP;
							window_max_q   <= FIELD_BOTTOM;
							sample_count_q <= '0;
							last_swing_q   <= swing_next;
							done_q         <= 1'b1;
							state_q        <= T_MAP;
						end else begin
							window_min_q   <= min_n;
							window_max_q   <= max_n;
							sample_count_q <= cnt_next;
							done_q         <= 1'b0;
							state_q        <= T_FIN;
						end
					end
				end
				T_MAP: begin
					if (map_rsp.done) begin
						last_watts_q <= map_rsp.watts;
						state_q      <= T_FIN;
					end
				end
				T_FIN: begin
					if (res_load) begin
						power_state_q <= pow_next;
						res_watts_q   <= last_watts_q;
						res_swing_q   <= last_swing_q;
						res_done_q    <= done_q;
						res_pow_q     <= pow_next;
						res_evt_q     <= evt_next;
						state_q       <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign result.valid       = res_valid_q;
	assign result.power_watts = res_watts_q;
	assign result.swing       = res_swing_q;
	assign result.window_done = res_done_q;
	assign result.power_on    = res_pow_q;
	assign result.event_code  = res_evt_q;

	// The mapping unit finishes only while the sequence waits for it.
	a_map_done_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		map_rsp.done |-> (state_q == T_MAP))
		else $error("mapping unit finished outside the mapping wait");

	// A window-closing sample always hands its swing to the mapping unit.
	a_close_starts_map: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_acc && close) |=> (state_q == T_MAP && done_q))
		else $error("window close did not start the wattage mapping");

	// A reported event always agrees with the reported power state.
	a_event_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_evt_q != EVT_ON || res_pow_q) &&
			(res_evt_q != EVT_OFF || !res_pow_q)))
		else $error("power event disagrees with power state");

endmodule

[src/fspd_map_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspd_map_unit: iterative swing to wattage mapping
// Maps a swing linearly (amp_low to 0, amp_high to watts_max) with one shared
// 25-bit add/subtract unit: range offsets and magnitudes, a 16-step shift-add
// multiply, a saturation check at 65535 watts and a 16-step restoring divide.
// ----------------------------------------------------------------------------
module fspd_map_unit
	import fspd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  map_req_t req,
	output map_rsp_t rsp
);

	localparam int OPW    = SWING_W + 1;
	localparam int PROD_W = SWING_W + WATTS_W;
	localparam int STEP_W = $clog2(WATTS_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WATTS_W - 1);

	typedef enum logic [3:0] {
		M_IDLE,
		M_NUM,
		M_NABS,
		M_DEN,
		M_DABS,
		M_MUL,
		M_CHK,
		M_DIV,
		M_DONE
	} map_state_t;

	map_state_t          state_q;
	logic [STEP_W-1:0]   step_q;
	logic [SWING_W-1:0]  swing_q;
	logic [SWING_W-1:0]  low_q;
	logic [SWING_W-1:0]  high_q;
	logic [WATTS_W-1:0]  wm_q;
	logic [OPW-1:0]      num_q;
	logic [OPW-1:0]      den_q;
	logic                sign_n_q;
	logic [PROD_W-1:0]   prod_q;
	logic [WATTS_W-1:0]  watts_q;

	logic [OPW-1:0]      op_a;
	logic [OPW-1:0]      op_b;
	logic                op_sub;
	logic [OPW:0]        sum;
	logic                qbit;
	logic [SWING_W-1:0]  rem_next;

	// Operand selection for the shared adder.
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			M_NUM: begin
				op_a   = {1'b0, swing_q};
				op_b   = {1'b0, low_q};
				op_sub = 1'b1;
			end
			M_NABS: begin
				op_b   = num_q;
				op_sub = 1'b1;
			end
			M_DEN: begin
				op_a   = {1'b0, high_q};
				op_b   = {1'b0, low_q};
				op_sub = 1'b1;
			end
			M_DABS: begin
				op_b   = den_q;
				op_sub = 1'b1;
			end
			M_MUL: begin
				op_a = {1'b0, prod_q[PROD_W-1:WATTS_W]};
				op_b = prod_q[0] ? {1'b0, num_q[SWING_W-1:0]} : '0;
			end
			M_CHK: begin
				op_a   = {1'b0, prod_q[PROD_W-1:WATTS_W]};
				op_b   = {1'b0, den_q[SWING_W-1:0]};
				op_sub = 1'b1;
			end
			M_DIV: begin
				op_a   = {prod_q[PROD_W-1:WATTS_W], prod_q[WATTS_W-1]};
				op_b   = {1'b0, den_q[SWING_W-1:0]};
				op_sub = 1'b1;
			end
			default: begin
				op_sub = 1'b0;
			end
		endcase
	end

	// Shared add/subtract unit; the carry out means no borrow on a subtract.
	assign sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + {{OPW{1'b0}}, op_sub};

	// Restoring divide step: keep the difference when it did not borrow.
	assign qbit     = sum[OPW];
	assign rem_next = qbit ? sum[SWING_W-1:0] : op_a[SWING_W-1:0];

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= M_IDLE;
			step_q   <= '0;
			swing_q  <= '0;
			low_q    <= '0;
			high_q   <= '0;
			wm_q     <= '0;
			num_q    <= '0;
			den_q    <= '0;
			sign_n_q <= 1'b0;
			prod_q   <= '0;
			watts_q  <= '0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						swing_q <= req.swing;
						low_q   <= req.amp_low;
						high_q  <= req.amp_high;
						wm_q    <= req.watts_max;
						state_q <= M_NUM;
					end
				end
				M_NUM: begin
					num_q   <= sum[OPW-1:0];
					state_q <= M_NABS;
				end
				M_NABS: begin
					sign_n_q <= num_q[OPW-1];
					if (num_q[OPW-1]) begin
						num_q <= sum[OPW-1:0];
					end
					state_q <= M_DEN;
				end
				M_DEN: begin
					den_q   <= sum[OPW-1:0];
					state_q <= M_DABS;
				end
				M_DABS: begin
					if (den_q[OPW-1]) begin
						den_q <= sum[OPW-1:0];
					end
					// An empty range or a negative quotient maps to zero watts.
					if (den_q == '0 || sign_n_q != den_q[OPW-1]) begin
						watts_q <= '0;
						state_q <= M_DONE;
					end else begin
						prod_q  <= {{SWING_W{1'b0}}, wm_q};
						step_q  <= '0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					prod_q <= {sum[OPW-1:0], prod_q[WATTS_W-1:1]};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= M_CHK;
					end
				end
				M_CHK: begin
					// A quotient of 65536 or more shows as high product >= divisor.
					if (sum[OPW]) begin
						watts_q <= WATTS_SAT;
						state_q <= M_DONE;
					end else begin
						step_q  <= '0;
						state_q <= M_DIV;
					end
				end
				M_DIV: begin
					prod_q <= {rem_next, prod_q[WATTS_W-2:0], qbit};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						watts_q <= {prod_q[WATTS_W-2:0], qbit};
						state_q <= M_DONE;
					end
				end
				M_DONE: begin
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = (state_q == M_DONE);
	assign rsp.watts = watts_q;

endmodule

[tb/sv/tb_field_swing_power_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_field_swing_power_detector_unit: self-checking bench of the swing detector
// Drives field samples and register writes over valid/ready channels, predicts
// every detector result in a scoreboard class and compares it field by field.
// A short directed run covers the range ends and corner cases, then random
// phases with random register settings follow.
// ----------------------------------------------------------------------------

// One detector result as the result channel carries it.
typedef struct packed {
	logic [fspd_pkg::WATTS_W-1:0] watts;
	logic [fspd_pkg::SWING_W-1:0] swing;
	logic                         done;
	logic                         on;
	fspd_pkg::event_code_t        evt;
} power_result_t;

// Swing and wattage predictor with a queue of results still to come.
class power_scoreboard;
	localparam int FB = fspd_pkg::FIELD_BITS_DEF;
	localparam longint FIELD_TOP = (longint'(1) <<< (FB - 1)) - 1;
	localparam longint FIELD_BOTTOM = -FIELD_TOP - 1;

	// Register copies.
	logic [fspd_pkg::WINDOW_W-1:0] win_len;
	logic [fspd_pkg::SWING_W-1:0]  amp_lo;
	logic [fspd_pkg::SWING_W-1:0]  amp_hi;
	logic [fspd_pkg::WATTS_W-1:0]  watts_full;
	logic                          cal;

	// Window and power state.
	longint                        win_min;
	longint                        win_max;
	logic [fspd_pkg::WINDOW_W-1:0] fill;
	logic [fspd_pkg::SWING_W-1:0]  swing_now;
	logic [fspd_pkg::WATTS_W-1:0]  watts_now;
	logic                          on_now;

	power_result_t                 results_due[$];
	int                            mismatches;

	function new();
		win_len = fspd_pkg::WINDOW_SAMPLES_RST;
		amp_lo = fspd_pkg::AMPLITUDE_LOW_RST;
		amp_hi = fspd_pkg::AMPLITUDE_HIGH_RST;
		watts_full = fspd_pkg::WATTS_MAX_RST;
		cal = 1'b0;
		win_min = FIELD_TOP;
		win_max = FIELD_BOTTOM;
		fill = '0;
		swing_now = '0;
		watts_now = '0;
		on_now = 1'b0;
		mismatches = 0;
	endfunction

	function void write_reg(logic [fspd_pkg::CFG_IDX_W-1:0] idx,
			logic [fspd_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			fspd_pkg::REG_WINDOW_SAMPLES: win_len = data[fspd_pkg::WINDOW_W-1:0];
			fspd_pkg::REG_AMPLITUDE_LOW:  amp_lo = data[fspd_pkg::SWING_W-1:0];
			fspd_pkg::REG_AMPLITUDE_HIGH: amp_hi = data[fspd_pkg::SWING_W-1:0];
			fspd_pkg::REG_WATTS_MAX:      watts_full = data[fspd_pkg::WATTS_W-1:0];
			fspd_pkg::REG_CALIBRATING:    cal = data[0];
			default: ;
		endcase
	endfunction

	// Linear map of a swing onto watts, truncating toward zero and clamped.
	function logic [fspd_pkg::WATTS_W-1:0] swing_to_watts(logic [fspd_pkg::SWING_W-1:0] amp);
		longint den;
		longint num;
		longint val;
		den = longint'(amp_hi) - longint'(amp_lo);
		if (den == 0)
			return '0;
		num = (longint'(amp) - longint'(amp_lo)) * longint'(watts_full);
		val = num / den;
		if (val < 0)
			return '0;
		if (val > longint'(fspd_pkg::WATTS_SAT))
			return fspd_pkg::WATTS_SAT;
		return val[fspd_pkg::WATTS_W-1:0];
	endfunction

	// Update the window with an accepted sample and queue the result it causes.
	function void note_sample(logic signed [FB-1:0] field);
		longint x;
		longint d;
		logic [fspd_pkg::WINDOW_W-1:0] lim;
		power_result_t r;
		x = field;
		lim = (win_len == 0) ? fspd_pkg::WINDOW_W'(1) : win_len;
		if (x < win_min)
			win_min = x;
		if (x > win_max)
			win_max = x;
		fill = fill + 1'b1;
		r.done = 1'b0;
		if (fill >= lim) begin
			d = win_max - win_min;
			if (d < 0)
				d = 0;
			if (d > longint'(fspd_pkg::SWING_MAX))
				d = longint'(fspd_pkg::SWING_MAX);
			swing_now = d[fspd_pkg::SWING_W-1:0];
			watts_now = swing_to_watts(swing_now);
			fill = '0;
			win_min = FIELD_TOP;
			win_max = FIELD_BOTTOM;
			r.done = 1'b1;
		end
		r.evt = fspd_pkg::EVT_NONE;
		if (!cal) begin
			if (watts_now != 0 && !on_now) begin
				on_now = 1'b1;
				r.evt = fspd_pkg::EVT_ON;
			end else if (watts_now == 0 && on_now) begin
				on_now = 1'b0;
				r.evt = fspd_pkg::EVT_OFF;
			end
		end
		r.watts = watts_now;
		r.swing = swing_now;
		r.on = on_now;
		results_due.push_back(r);
	endfunction

	function void report(string name, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		mismatches++;
	endfunction

	// Compare an accepted result with the oldest prediction.
	function void check_result(power_result_t got);
		power_result_t want;
		if (results_due.size() == 0) begin
			$display("%0t: result with no sample pending, expected none, actual watts %0d",
				$time, got.watts);
			mismatches++;
			return;
		end
		want = results_due.pop_front();
		if (got.watts !== want.watts)
			report("power_watts", want.watts, got.watts);
		if (got.swing !== want.swing)
			report("swing", want.swing, got.swing);
		if (got.done !== want.done)
			report("window_done", want.done, got.done);
		if (got.on !== want.on)
			report("power_on", want.on, got.on);
		if (got.evt !== want.evt)
			report("event_code", want.evt, got.evt);
	endfunction

	function int pending();
		return results_due.size();
	endfunction
endclass

module tb_field_swing_power_detector_unit;
	import fspd_pkg::*;

	localparam int SAMPLE_TARGET = 1650;
	localparam int CYCLE_LIMIT = 600000;
	localparam int FB = FIELD_BITS_DEF;
	localparam longint FIELD_TOP = (longint'(1) <<< (FB - 1)) - 1;
	localparam longint FIELD_BOTTOM = -FIELD_TOP - 1;

	logic clk;
	logic arst_n;
	bit   no_idle;

	power_scoreboard sb;

	fspd_in_if #(.FIELD_BITS(FB)) sample_ch();
	fspd_out_if result_ch();
	fspd_cfg_if cfg_ch();

	field_swing_power_detector_unit #(.FIELD_BITS(FB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall cycle limit.
	initial begin : watchdog
		int n;
		for (n = 0; n < CYCLE_LIMIT; n++)
			@(posedge clk);
		$display("field_swing_power_detector_unit: mismatch");
		$finish;
	end

	// Result sink: random stalls, every accepted transaction is checked.
	initial begin : result_sink
		power_result_t got;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got.watts = result_ch.power_watts;
				got.swing = result_ch.swing;
				got.done = result_ch.window_done;
				got.on = result_ch.power_on;
				got.evt = event_code_t'(result_ch.event_code);
				sb.check_result(got);
			end
			@(negedge clk);
			result_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
		end
	end

	// Send one field sample; valid stays high into the next call unless it idles.
	task automatic send_sample(input logic signed [FB-1:0] value);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 30) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.field_z <= value;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		sb.note_sample(value);
	endtask

	// Stop sending and wait until every predicted result has been taken.
	task automatic drain_results();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One register write transaction.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Pick a register setting, with the range ends now and then.
	task automatic random_config();
		logic [CFG_DATA_W-1:0] win;
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [CFG_DATA_W-1:0] wm;
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			win = 0;
		else if (r == 2)
			win = 16'hFFFF;
		else if (r < 13)
			win = CFG_DATA_W'($urandom_range(1, 8));
		else if (r < 18)
			win = CFG_DATA_W'($urandom_range(9, 40));
		else
			win = CFG_DATA_W'($urandom_range(41, 200));
		r = $urandom_range(0, 9);
		if (r < 5)
			lo = CFG_DATA_W'($urandom_range(0, 1500));
		else if (r == 5)
			lo = 0;
		else if (r == 6)
			lo = 24'hFFFFFF;
		else
			lo = CFG_DATA_W'($urandom());
		r = $urandom_range(0, 9);
		if (r < 6)
			hi = lo + CFG_DATA_W'($urandom_range(1, 3000));
		else if (r == 6)
			hi = lo;
		else if (r == 7)
			hi = lo - CFG_DATA_W'($urandom_range(1, 1000));
		else if (r == 8)
			hi = 24'hFFFFFF;
		else
			hi = CFG_DATA_W'($urandom());
		r = $urandom_range(0, 9);
		if (r < 7)
			wm = CFG_DATA_W'($urandom_range(0, 65535));
		else if (r == 7)
			wm = 0;
		else if (r == 8)
			wm = 16'hFFFF;
		else
			wm = CFG_DATA_W'($urandom_range(1, 10));
		write_reg(REG_WINDOW_SAMPLES, win);
		write_reg(REG_AMPLITUDE_LOW, lo);
		write_reg(REG_AMPLITUDE_HIGH, hi);
		write_reg(REG_WATTS_MAX, wm);
		write_reg(REG_CALIBRATING, CFG_DATA_W'(($urandom_range(0, 6) == 0) ? 1 : 0));
	endtask

	// Random samples around a center, with the spread redrawn every few samples
	// so that swings fall below, inside and above the mapped range.
	task automatic random_phase(input int count);
		int i;
		int left;
		int unsigned spread;
		longint center;
		longint v;
		logic signed [FB-1:0] raw;
		raw = FB'($urandom());
		center = raw;
		left = 0;
		spread = 0;
		for (i = 0; i < count; i++) begin
			if (left == 0) begin
				left = $urandom_range(1, 12);
				case ($urandom_range(0, 3))
					0: spread = 0;
					1: spread = $urandom_range(0, 2000);
					2: spread = $urandom_range(0, 1 << 20);
					default: spread = $urandom_range(0, 1 << 24);
				endcase
				if ($urandom_range(0, 3) == 0) begin
					raw = FB'($urandom());
					center = raw;
				end
			end
			left--;
			if ($urandom_range(0, 9) == 0) begin
				raw = FB'($urandom());
				v = raw;
			end else begin
				v = center + longint'($urandom_range(0, spread)) - longint'(spread / 2);
			end
			if (v > FIELD_TOP)
				v = FIELD_TOP;
			if (v < FIELD_BOTTOM)
				v = FIELD_BOTTOM;
			// Now and then hold the sender until the block has caught up.
			if ($urandom_range(0, 199) == 0)
				drain_results();
			send_sample(v[FB-1:0]);
		end
		drain_results();
	endtask

	// Main sequence.
	initial begin : main_seq
		int sent;
		int phase;
		int n;
		sb = new();
		no_idle = 1'b0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.field_z = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_WINDOW_SAMPLES;
		cfg_ch.wdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Range ends of the samples, saturated watts, drop to zero, mid-range.
		write_reg(REG_WINDOW_SAMPLES, 2);
		write_reg(REG_AMPLITUDE_LOW, 0);
		write_reg(REG_AMPLITUDE_HIGH, 1000);
		write_reg(REG_WATTS_MAX, 3000);
		write_reg(REG_CALIBRATING, 0);
		send_sample(-24'sd8388608);
		send_sample(24'sd8388607);
		send_sample(0);
		send_sample(0);
		send_sample(100);
		send_sample(-400);
		drain_results();

		// Equal range ends give zero watts.
		write_reg(REG_WINDOW_SAMPLES, 1);
		write_reg(REG_AMPLITUDE_LOW, 500);
		write_reg(REG_AMPLITUDE_HIGH, 500);
		send_sample(5);
		drain_results();

		// Inverted range with the widest register values.
		write_reg(REG_WINDOW_SAMPLES, 2);
		write_reg(REG_AMPLITUDE_LOW, 24'hFFFFFF);
		write_reg(REG_AMPLITUDE_HIGH, 0);
		write_reg(REG_WATTS_MAX, 16'hFFFF);
		send_sample(-24'sd8388608);
		send_sample(24'sd8388607);
		send_sample(0);
		send_sample(1000);
		drain_results();

		// A zero window length closes on every sample.
		write_reg(REG_WINDOW_SAMPLES, 0);
		send_sample(7);
		send_sample(-7);
		drain_results();

		// Calibration freezes the power state; the off event comes once released.
		write_reg(REG_CALIBRATING, 1);
		write_reg(REG_AMPLITUDE_LOW, 0);
		write_reg(REG_AMPLITUDE_HIGH, 24'hFFFFFF);
		write_reg(REG_WATTS_MAX, 0);
		write_reg(REG_WINDOW_SAMPLES, 1);
		send_sample(1);
		send_sample(2);
		drain_results();
		write_reg(REG_CALIBRATING, 0);
		send_sample(3);
		drain_results();

		// Longest window, then shortened below the samples already taken.
		write_reg(REG_WINDOW_SAMPLES, 16'hFFFF);
		write_reg(REG_WATTS_MAX, 3000);
		write_reg(REG_AMPLITUDE_HIGH, 1000);
		send_sample(10);
		send_sample(20);
		send_sample(30);
		drain_results();
		write_reg(REG_WINDOW_SAMPLES, 2);
		send_sample(40);
		drain_results();

		// Random phases, each under its own register setting.
		sent = 0;
		phase = 0;
		while (sent < SAMPLE_TARGET) begin
			random_config();
			no_idle = (phase == 3 || phase == 4);
			n = $urandom_range(40, 160);
			random_phase(n);
			sent += n;
			phase++;
		end
		no_idle = 1'b0;

		drain_results();
		repeat (45) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("field_swing_power_detector_unit: match");
		else
			$display("field_swing_power_detector_unit: mismatch");
		$finish;
	end

endmodule
